>>> design/assert_macros.svh
// Assertion macros used by the top level of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mfld_pkg.sv
// Shared types and constants of the framebuffer line drawer.
package mfld_pkg;
    localparam int ScreenWidth = 84;
    localparam int ScreenBanks = 6;
    localparam int StoreBytes = ScreenWidth * ScreenBanks;
    localparam int ScreenRows = ScreenBanks * 8;
    localparam int AddrW = 9;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PLOT = 2'd1;
    localparam logic [1:0] CMD_LINE = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    // One decoded command as it travels from the front to the back part.
    typedef struct packed {
        logic [1:0] command;
        logic [6:0] x_start;
        logic [5:0] y_start;
        logic [6:0] x_end;
        logic [5:0] y_end;
        logic       pixel_on;
        logic [8:0] read_address;
        logic       addr_ok;
    } cmd_t;
endpackage

>>> design/mfld_front.sv
// Front part: accepts command beats, classifies them, and queues them.
module mfld_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [39:0]      in_data,
    output logic             q_valid,
    input  logic             q_ready,
    output mfld_pkg::cmd_t   q_cmd
);
    import mfld_pkg::*;

    cmd_t        fifo_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    cmd_t        dec;
    logic        push, pop;

    // Unpack and classify the incoming beat.
    always_comb
    begin
        dec.command      = in_data[1:0];
        dec.x_start      = in_data[8:2];
        dec.y_start      = in_data[14:9];
        dec.x_end        = in_data[21:15];
        dec.y_end        = in_data[27:22];
        dec.pixel_on     = in_data[28];
        dec.read_address = in_data[37:29];
        dec.addr_ok      = (in_data[37:29] < AddrW'(StoreBytes));
    end

    assign in_ready = (cnt_reg != 3'd4);
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_cmd    = fifo_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= dec;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

>>> design/mfld_div.sv
// Restoring divider, one quotient bit per cycle, for 13-bit by 7-bit quotients.
module mfld_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [12:0] dividend,
    input  logic [6:0] divisor,
    output logic       done,
    output logic [12:0] quotient
);
    import mfld_pkg::*;

    logic [12:0] q_reg;
    logic [7:0]  r_reg;
    logic [3:0]  n_reg;
    logic        busy_reg;
    logic [7:0]  trial;

    assign trial    = {r_reg[6:0], q_reg[12]};
    assign done     = busy_reg && (n_reg == 4'd0);
    assign quotient = q_reg;

    // One shift-subtract step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 4'd13;
            q_reg    <= dividend;
            r_reg    <= '0;
        end
        else if (busy_reg && n_reg != 4'd0)
        begin
            n_reg <= n_reg - 4'd1;
            if (trial >= {1'b0, divisor})
            begin
                r_reg <= trial - {1'b0, divisor};
                q_reg <= {q_reg[11:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[11:0], 1'b0};
            end
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end
endmodule

>>> design/mfld_back.sv
// Back part: clears, plots, draws lines and reads the display store.
module mfld_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mfld_pkg::cmd_t q_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_data
);
    import mfld_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_RDCMD = 4'd7;
    localparam logic [3:0] S_RDOUT = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_SETUP = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;

    logic [7:0] mem [StoreBytes];
    logic [3:0] st_reg;
    cmd_t       c_reg;
    logic [8:0] addr_reg;
    logic [7:0] rdata_reg;
    logic [6:0] k_reg, maj_reg, mnr_reg;
    logic       xmaj_reg, sx_reg, sy_reg, endpt_reg;
    logic [7:0] px_reg, py_reg;
    logic [7:0] obuf_reg;
    logic       ovalid_reg;
    logic [2:0] bit_reg;
    logic       div_start, div_done;
    logic [12:0] quo;
    logic [6:0] adx, ady;
    logic [8:0] pix_addr;
    logic       pix_ok;
    logic       mem_we;
    logic [7:0] mem_wd;

    assign adx = (c_reg.x_end >= c_reg.x_start) ? c_reg.x_end - c_reg.x_start
                                                : c_reg.x_start - c_reg.x_end;
    assign ady = {1'b0, (c_reg.y_end >= c_reg.y_start) ? c_reg.y_end - c_reg.y_start
                                                       : c_reg.y_start - c_reg.y_end};

    assign q_ready   = (st_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign div_start = (st_reg == S_STEP) && !endpt_reg && (k_reg != maj_reg);

    mfld_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(13'(mnr_reg * k_reg)), .divisor(maj_reg),
        .done(div_done), .quotient(quo)
    );

    // Store address of the current pixel; bank times width plus column.
    always_comb
    begin
        pix_ok   = (px_reg < 8'(ScreenWidth)) && (py_reg < 8'(ScreenRows));
        pix_addr = 9'(({6'b0, py_reg[5:3]} * 9'(ScreenWidth)) + {2'b0, px_reg[6:0]});
    end

    // Store write data.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wd = 8'h00;
        if (st_reg == S_CLR || st_reg == S_INIT)
        begin
            mem_we = 1'b1;
        end
        else if (st_reg == S_WR)
        begin
            mem_we = 1'b1;
            mem_wd = c_reg.pixel_on ? (rdata_reg | (8'd1 << bit_reg))
                                    : (rdata_reg & ~(8'd1 << bit_reg));
        end
    end

    // Store memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[addr_reg] <= mem_wd;
        rdata_reg <= mem[addr_reg];
    end

    // Command sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_INIT;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
            obuf_reg   <= '0;
            c_reg      <= '0;
            k_reg      <= '0; maj_reg <= '0; mnr_reg <= '0;
            xmaj_reg   <= 1'b0; sx_reg <= 1'b0; sy_reg <= 1'b0; endpt_reg <= 1'b0;
            px_reg     <= '0; py_reg <= '0; bit_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            case (st_reg)
                S_INIT:
                begin
                    addr_reg <= addr_reg + 9'd1;
                    if (addr_reg == 9'(StoreBytes - 1)) st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        c_reg <= q_cmd;
                        case (q_cmd.command)
                            CMD_CLEAR:
                            begin
                                addr_reg <= '0;
                                st_reg   <= S_CLR;
                            end
                            CMD_PLOT:
                            begin
                                px_reg    <= {1'b0, q_cmd.x_start};
                                py_reg    <= {2'b0, q_cmd.y_start};
                                endpt_reg <= 1'b1;
                                maj_reg   <= '0;
                                k_reg     <= '0;
                                st_reg    <= S_DIV;
                            end
                            CMD_LINE:
                            begin
                                k_reg     <= '0;
                                endpt_reg <= 1'b0;
                                st_reg    <= S_SETUP;
                            end
                            default:
                            begin
                                addr_reg <= q_cmd.read_address;
                                st_reg   <= S_RDCMD;
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    addr_reg <= addr_reg + 9'd1;
                    if (addr_reg == 9'(StoreBytes - 1)) st_reg <= S_DONE;
                end
                S_SETUP:
                begin
                    // Pick the major axis and the step directions of the line.
                    xmaj_reg <= (adx >= ady);
                    maj_reg  <= (adx >= ady) ? adx : ady;
                    mnr_reg  <= (adx >= ady) ? ady : adx;
                    sx_reg   <= (c_reg.x_end < c_reg.x_start);
                    sy_reg   <= (c_reg.y_end < c_reg.y_start);
                    st_reg   <= S_STEP;
                end
                S_STEP:
                begin
                    st_reg <= S_DIV;
                    if (k_reg == maj_reg)
                    begin
                        px_reg    <= {1'b0, c_reg.x_end};
                        py_reg    <= {2'b0, c_reg.y_end};
                        endpt_reg <= 1'b1;
                    end
                    else
                    begin
                        endpt_reg <= 1'b0;
                    end
                end
                S_DIV:
                begin
                    if (endpt_reg || div_done)
                    begin
                        if (!endpt_reg)
                        begin
                            if (xmaj_reg)
                            begin
                                px_reg <= sx_reg ? 8'(c_reg.x_start - k_reg)
                                                 : 8'(c_reg.x_start + k_reg);
                                py_reg <= sy_reg ? 8'({2'b0, c_reg.y_start} - quo[7:0])
                                                 : 8'({2'b0, c_reg.y_start} + quo[7:0]);
                            end
                            else
                            begin
                                px_reg <= sx_reg ? 8'({1'b0, c_reg.x_start} - quo[7:0])
                                                 : 8'({1'b0, c_reg.x_start} + quo[7:0]);
                                py_reg <= sy_reg ? 8'({2'b0, c_reg.y_start} - {1'b0, k_reg})
                                                 : 8'({2'b0, c_reg.y_start} + {1'b0, k_reg});
                            end
                        end
                        st_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // Coordinates are settled; address the byte.
                    if (pix_ok)
                    begin
                        addr_reg <= pix_addr;
                        bit_reg  <= py_reg[2:0];
                        st_reg   <= S_RDW;
                    end
                    else
                    begin
                        st_reg <= S_RDOUT;
                    end
                end
                S_RDW:
                begin
                    // The registered read of the new address lands at this edge.
                    st_reg <= S_WR;
                end
                S_WR:
                begin
                    st_reg <= S_RDOUT;
                end
                S_RDOUT:
                begin
                    if (c_reg.command == CMD_LINE && !endpt_reg)
                    begin
                        k_reg  <= k_reg + 7'd1;
                        st_reg <= S_STEP;
                    end
                    else
                    begin
                        st_reg <= S_DONE;
                    end
                end
                S_RDCMD:
                begin
                    st_reg <= S_RDOUT;
                end
                S_DONE:
                begin
                    // Load the result only once the previous beat has left.
                    if (!ovalid_reg || out_ready)
                    begin
                        obuf_reg   <= (c_reg.command == CMD_READ && c_reg.addr_ok)
                                      ? rdata_reg : 8'h00;
                        ovalid_reg <= 1'b1;
                        st_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> design/mono_framebuffer_line_drawer.sv
// Top level of the monochrome framebuffer line drawer.
// Keeps an 84x48 one-bit display store (6 banks of 84 column bytes) and runs
// one command per beat: clear, plot a pixel, draw a line, or read a byte.
// Each command returns one result beat. After reset the store is cleared,
// byte by byte, before the first command runs. A line is drawn point by
// point along its major axis after a setup step; for each point before the
// end point the bit-serial divider forms the minor coordinate, and each
// point on the screen gets one read-modify-write of the store.
// A four-entry command queue lets new beats arrive while a command runs.
`include "assert_macros.svh"
module mono_framebuffer_line_drawer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], x_start[8:2], y_start[14:9], x_end[21:15], y_end[27:22],
    // pixel_on[28], read_address[37:29], zero fill to 40 bits
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);
    import mfld_pkg::*;

    logic  q_valid, q_ready;
    cmd_t  q_cmd;

    mfld_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mfld_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

    // Taking a command always moves the back part out of idle.
    `ASSERT_NEXT(a_take_leaves, clk, rst_n, q_valid && q_ready, !q_ready)
    // A result beat never carries unknown bits.
    `ASSERT_IMPL(a_out_known, clk, rst_n, m_tvalid, !$isunknown(m_tdata))
endmodule
